// File: design/id3_pkg.sv
// ----------------------------------------------------------------------------
// id3_pkg
// Shared types, codes and tables of the ID3v2 tag stream parser.
// ----------------------------------------------------------------------------
package id3_pkg;

    localparam int ID3_QUEUE_DEPTH = 4;
    localparam int NUM_FIELDS      = 11;

    localparam logic [3:0] NO_FIELD      = 4'd15;
    localparam logic [3:0] COMMENT_FIELD = 4'd10;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_TAG   = 2'd1,
        KIND_RATE  = 2'd2,
        KIND_NOTAG = 2'd3
    } id3_kind_t;

    // Frame idents in field code order: TIT2 TPE1 TALB TYER TRCK TCON
    // TCOM TSSE TCOP WXXX COMM.
    localparam logic [31:0] FIELD_IDENTS [NUM_FIELDS] = '{
        32'h54495432, 32'h54504531, 32'h54414C42, 32'h54594552,
        32'h5452434B, 32'h54434F4E, 32'h54434F4D, 32'h54535345,
        32'h54434F50, 32'h57585858, 32'h434F4D4D
    };

    // MPEG-1 Layer III bitrates in kbps, by bitrate index.
    localparam logic [8:0] RATE_KBPS [16] = '{
        9'd0,   9'd32,  9'd40,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };

    typedef struct packed {
        id3_kind_t   kind;
        logic [3:0]  field_code;
        logic [7:0]  text_byte;
        logic        text_valid;
        logic        field_last;
        logic [7:0]  tag_version;
        logic [28:0] tag_total_size;
        logic [3:0]  rate_index;
    } id3_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } id3_qstat_t;

endpackage

// File: design/id3_in_if.sv
// ----------------------------------------------------------------------------
// id3_in_if
// Byte stream channel into the parser.
// ----------------------------------------------------------------------------
interface id3_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);

endinterface

// File: design/id3_out_if.sv
// ----------------------------------------------------------------------------
// id3_out_if
// Result channel out of the parser.
// ----------------------------------------------------------------------------
interface id3_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  field_code;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        field_last;
    logic [7:0]  tag_version;
    logic [28:0] tag_total_size;
    logic [8:0]  bitrate_kbps;

    modport source (
        output valid, output kind, output field_code, output text_byte,
        output text_valid, output field_last, output tag_version,
        output tag_total_size, output bitrate_kbps, input ready
    );
    modport sink (
        input valid, input kind, input field_code, input text_byte,
        input text_valid, input field_last, input tag_version,
        input tag_total_size, input bitrate_kbps, output ready
    );

endinterface

// File: design/id3_front.sv
// ----------------------------------------------------------------------------
// id3_front
// Byte parser: header check, syncsafe size, frame walk and sync search.
// Emits one result record per byte at most into the queue.
// ----------------------------------------------------------------------------
module id3_front (
    input  logic                clk,
    input  logic                rst_n,
    id3_in_if.sink              stream,
    input  id3_pkg::id3_qstat_t qstat,
    output logic                push,
    output id3_pkg::id3_rec_t   push_rec
);
    import id3_pkg::*;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_FHDR   = 6'b000010,
        PH_FBODY  = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_SYNC   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_3 = 8'h33;

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [27:0] tbs_reg, tbs_next;
    logic [27:0] rem_reg, rem_next;
    logic [31:0] ident_reg, ident_next;
    logic [31:0] len_reg, len_next;
    logic [27:0] bi_reg, bi_next;
    logic [3:0]  field_reg, field_next;
    logic        nul_reg, nul_next;
    logic [15:0] win_reg, win_next;
    logic [7:0]  version_reg, version_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] off_eff;
    phase_t      ph_base, ph;
    logic        to_sync;
    logic [27:0] bi;
    logic [28:0] skip_limit;
    logic [3:0]  hoff;
    logic        hlow;
    logic [27:0] tbs_shift;
    logic [27:0] rem_less10;
    logic [27:0] bi_inc;
    logic [27:0] rem_after;
    logic [3:0]  match_field;
    logic [2:0]  skip_cnt;
    logic        nul_upd;

    assign stream.ready = !qstat.full;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.data_byte;

    assign off_eff    = stream.first_byte ? 32'd0 : offset_reg;
    assign ph_base    = stream.first_byte ? PH_HEADER : phase_reg;
    assign skip_limit = {1'b0, tbs_reg} + 29'd10;
    assign to_sync    = (ph_base == PH_SKIP) && ({3'b000, skip_limit} <= off_eff);
    assign ph         = to_sync ? PH_SYNC : ph_base;
    assign bi         = to_sync ? 28'd0 : bi_reg;

    assign hoff       = off_eff[3:0];
    assign hlow       = (off_eff[31:4] == 28'd0);
    assign tbs_shift  = {tbs_reg[20:0], b[6:0]};
    assign rem_less10 = rem_reg - 28'd10;
    assign bi_inc     = bi + 28'd1;
    assign rem_after  = rem_reg - len_reg[27:0];
    assign skip_cnt   = (field_reg == COMMENT_FIELD) ? 3'd4 : 3'd1;
    assign nul_upd    = nul_reg || (b == 8'h00);

    always_comb
    begin
        match_field = NO_FIELD;
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            if (ident_reg == FIELD_IDENTS[k])
            begin
                match_field = 4'(k);
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        tbs_next     = tbs_reg;
        rem_next     = rem_reg;
        ident_next   = ident_reg;
        len_next     = len_reg;
        bi_next      = bi_reg;
        field_next   = field_reg;
        nul_next     = nul_reg;
        win_next     = win_reg;
        version_next = version_reg;
        push         = 1'b0;
        push_rec     = '0;

        if (accept)
        begin
            phase_next  = ph;
            bi_next     = bi;
            offset_next = (off_eff == 32'hFFFF_FFFF) ? off_eff : off_eff + 32'd1;

            unique case (ph)
                PH_HEADER:
                begin
                    if (hlow && ((hoff == 4'd0 && b != CHAR_I) ||
                                 (hoff == 4'd1 && b != CHAR_D) ||
                                 (hoff == 4'd2 && b != CHAR_3)))
                    begin
                        push          = 1'b1;
                        push_rec.kind = KIND_NOTAG;
                        phase_next    = PH_SYNC;
                        win_next      = {8'h00, b};
                        bi_next       = 28'd1;
                    end
                    else if (hlow && hoff == 4'd3)
                    begin
                        version_next = b;
                    end
                    else if (hlow && hoff >= 4'd6)
                    begin
                        tbs_next = tbs_shift;
                        if (hoff == 4'd9)
                        begin
                            push                    = 1'b1;
                            push_rec.kind           = KIND_TAG;
                            push_rec.tag_version    = version_reg;
                            push_rec.tag_total_size = {1'b0, tbs_shift} + 29'd10;
                            rem_next                = tbs_shift;
                            bi_next                 = 28'd0;
                            phase_next = (tbs_shift >= 28'd10) ? PH_FHDR : PH_SKIP;
                        end
                    end
                end
                PH_FHDR:
                begin
                    if (bi == 28'd0 && (rem_reg < 28'd10 || b == 8'h00))
                    begin
                        phase_next = PH_SKIP;
                        bi_next    = 28'd0;
                    end
                    else
                    begin
                        if (bi < 28'd4)
                        begin
                            ident_next = {ident_reg[23:0], b};
                        end
                        else if (bi < 28'd8)
                        begin
                            len_next = {len_reg[23:0], b};
                        end
                        bi_next = bi_inc;
                        if (bi_inc == 28'd10)
                        begin
                            bi_next = 28'd0;
                            if (len_reg == 32'd0 || len_reg > {4'h0, rem_less10})
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                rem_next   = rem_less10;
                                nul_next   = 1'b0;
                                phase_next = PH_FBODY;
                                if (match_field == COMMENT_FIELD && len_reg <= 32'd4)
                                begin
                                    field_next = NO_FIELD;
                                end
                                else
                                begin
                                    field_next = match_field;
                                end
                            end
                        end
                    end
                end
                PH_FBODY:
                begin
                    if (field_reg != NO_FIELD && bi >= {25'd0, skip_cnt})
                    begin
                        nul_next            = nul_upd;
                        push                = 1'b1;
                        push_rec.kind       = KIND_TEXT;
                        push_rec.field_code = field_reg;
                        push_rec.text_byte  = b;
                        push_rec.text_valid = !nul_upd;
                        push_rec.field_last = ({4'h0, bi_inc} == len_reg);
                    end
                    bi_next = bi_inc;
                    if ({4'h0, bi_inc} == len_reg)
                    begin
                        rem_next   = rem_after;
                        bi_next    = 28'd0;
                        phase_next = (rem_after != 28'd0) ? PH_FHDR : PH_SKIP;
                    end
                end
                PH_SYNC:
                begin
                    if (bi >= 28'd2 && win_reg[15:8] == 8'hFF && win_reg[7:5] == 3'b111)
                    begin
                        push                = 1'b1;
                        push_rec.kind       = KIND_RATE;
                        push_rec.rate_index = b[7:4];
                        phase_next          = PH_DONE;
                    end
                    else
                    begin
                        win_next = {win_reg[7:0], b};
                        if (bi < 28'd2)
                        begin
                            bi_next = bi_inc;
                        end
                    end
                end
                PH_SKIP, PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbs_reg     <= tbs_next;
        rem_reg     <= rem_next;
        ident_reg   <= ident_next;
        len_reg     <= len_next;
        bi_reg      <= bi_next;
        field_reg   <= field_next;
        nul_reg     <= nul_next;
        win_reg     <= win_next;
        version_reg <= version_next;
    end

endmodule

// File: design/id3_queue.sv
// ----------------------------------------------------------------------------
// id3_queue
// Short record queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module id3_queue #(
    parameter int DEPTH = id3_pkg::ID3_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  id3_pkg::id3_rec_t   push_rec,
    input  logic                pop,
    output id3_pkg::id3_rec_t   head_rec,
    output id3_pkg::id3_qstat_t qstat
);
    import id3_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    id3_rec_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_rec    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: design/id3_back.sv
// ----------------------------------------------------------------------------
// id3_back
// Output stage: formats queued records, looks up the bitrate and holds
// the result register.
// ----------------------------------------------------------------------------
module id3_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  id3_pkg::id3_rec_t head_rec,
    output logic              pop,
    id3_out_if.source         result
);
    import id3_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [3:0]  field_reg, field_next;
    logic [7:0]  text_reg, text_next;
    logic        tvalid_reg, tvalid_next;
    logic        last_reg, last_next;
    logic [7:0]  version_reg, version_next;
    logic [28:0] size_reg, size_next;
    logic [8:0]  rate_reg, rate_next;

    assign pop = head_valid && (!valid_reg || result.ready);

    always_comb
    begin
        kind_next    = head_rec.kind;
        field_next   = 4'd0;
        text_next    = 8'd0;
        tvalid_next  = 1'b0;
        last_next    = 1'b0;
        version_next = 8'd0;
        size_next    = 29'd0;
        rate_next    = 9'd0;
        unique case (head_rec.kind)
            KIND_TEXT:
            begin
                field_next  = head_rec.field_code;
                text_next   = head_rec.text_byte;
                tvalid_next = head_rec.text_valid;
                last_next   = head_rec.field_last;
            end
            KIND_TAG:
            begin
                version_next = head_rec.tag_version;
                size_next    = head_rec.tag_total_size;
            end
            KIND_RATE:
            begin
                rate_next = RATE_KBPS[head_rec.rate_index];
            end
            KIND_NOTAG:
            begin
            end
            default:
            begin
            end
        endcase

        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= kind_next;
            field_reg   <= field_next;
            text_reg    <= text_next;
            tvalid_reg  <= tvalid_next;
            last_reg    <= last_next;
            version_reg <= version_next;
            size_reg    <= size_next;
            rate_reg    <= rate_next;
        end
    end

    assign result.valid          = valid_reg;
    assign result.kind           = kind_reg;
    assign result.field_code     = field_reg;
    assign result.text_byte      = text_reg;
    assign result.text_valid     = tvalid_reg;
    assign result.field_last     = last_reg;
    assign result.tag_version    = version_reg;
    assign result.tag_total_size = size_reg;
    assign result.bitrate_kbps   = rate_reg;

endmodule

// File: design/id3v2_tag_stream_parser.sv
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser
// ID3v2.3 tag parser with first MPEG sync bitrate report.
//
// stream: one file byte per transfer; first_byte restarts the parse.
// result: at most one record per byte: field text bytes, tag header info,
//   no-tag notice, or the bitrate of the first MP3 frame.
// Throughput: one byte per cycle while the queue is not full.
// Path: each result record goes from the parser step into the queue,
//   then into the output register.
// The parser and the output stage meet through a record queue of
//   QUEUE_DEPTH entries; when result stalls, the queue fills and
//   stream.ready drops once it is full. Bytes that give no result never
//   wait on the output side except through a full queue.
// Reset: the parse restarts at the header, the queue and the output
//   register empty; no result is pending.
// ----------------------------------------------------------------------------
module id3v2_tag_stream_parser #(
    parameter int QUEUE_DEPTH = id3_pkg::ID3_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    id3_in_if.sink    stream,
    id3_out_if.source result
);
    import id3_pkg::*;

    logic       push;
    id3_rec_t   push_rec;
    logic       pop;
    id3_rec_t   head_rec;
    id3_qstat_t qstat;

    id3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .qstat    (qstat),
        .push     (push),
        .push_rec (push_rec)
    );

    id3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .qstat    (qstat)
    );

    id3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!qstat.empty),
        .head_rec   (head_rec),
        .pop        (pop),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("record pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("record popped from empty queue");

    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (!qstat.empty && (!result.valid || result.ready)) |=> result.valid)
        else $error("queued record not moved to output");
`endif

endmodule

// File: bench/id3_parse_checker.sv
// ----------------------------------------------------------------------------
// id3_parse_checker
// Watches the byte stream and the result channel of the ID3v2 tag stream
// parser. Every byte transfer runs through a local model of the parse, and
// any record it produces is queued. Every result transfer is compared field
// by field with the oldest queued record. Failures are counted for the top.
// ----------------------------------------------------------------------------
module id3_parse_checker (
    input  logic clk,
    input  logic rst_n,
    id3_in_if    stream,
    id3_out_if   result,
    output int   fails,
    output int   backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    import id3_pkg::*;

    localparam int MAX_REPORTS = 10;

    localparam logic [23:0] TAG_MAGIC = "ID3";

    localparam logic [31:0] KNOWN_IDENTS [11] = '{
        "TIT2", "TPE1", "TALB", "TYER", "TRCK", "TCON",
        "TCOM", "TSSE", "TCOP", "WXXX", "COMM"
    };

    localparam logic [8:0] KBPS_BY_INDEX [16] = '{
        9'd0,   9'd32,  9'd40,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };

    typedef enum logic [5:0] {
        WALK_HEADER     = 6'b000001,
        WALK_FRAME_HDR  = 6'b000010,
        WALK_FRAME_BODY = 6'b000100,
        WALK_SKIP       = 6'b001000,
        WALK_SYNC       = 6'b010000,
        WALK_DONE       = 6'b100000
    } walk_phase_t;

    typedef struct packed {
        id3_kind_t   kind;
        logic [3:0]  field_code;
        logic [7:0]  text_byte;
        logic        text_valid;
        logic        field_last;
        logic [7:0]  tag_version;
        logic [28:0] tag_total_size;
        logic [8:0]  bitrate_kbps;
    } parse_rec_t;

    walk_phase_t ph;
    logic [31:0] byte_pos;
    logic [27:0] tag_size;
    logic [28:0] consumed;
    logic [31:0] hdr_ident;
    logic [31:0] hdr_len;
    logic [31:0] idx;
    logic [3:0]  cur_field;
    logic        saw_nul;
    logic [15:0] last_two;
    logic [7:0]  major_ver;

    parse_rec_t pending_records [$];

    task automatic restart_parse();
        ph        = WALK_HEADER;
        byte_pos  = '0;
        tag_size  = '0;
        consumed  = '0;
        hdr_ident = '0;
        hdr_len   = '0;
        idx       = '0;
        cur_field = '0;
        saw_nul   = 1'b0;
        last_two  = '0;
        major_ver = '0;
    endtask

    task automatic finish_walk();
        ph  = WALK_SKIP;
        idx = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic first,
                              output bit produced, output parse_rec_t rec);
        logic [31:0] off;
        logic [31:0] room;
        logic [31:0] lead;
        int k;
        produced = 1'b0;
        rec      = '0;
        if (first)
            restart_parse();
        off = byte_pos;

        if (ph == WALK_SKIP && off >= 32'(tag_size) + 32'd10)
        begin
            ph  = WALK_SYNC;
            idx = '0;
        end

        unique case (ph)
            WALK_HEADER:
            begin
                if ((off == 0 && b != TAG_MAGIC[23:16]) ||
                    (off == 1 && b != TAG_MAGIC[15:8]) ||
                    (off == 2 && b != TAG_MAGIC[7:0]))
                begin
                    produced = 1'b1;
                    rec.kind = KIND_NOTAG;
                    ph       = WALK_SYNC;
                    last_two = {8'h00, b};
                    idx      = 32'd1;
                end
                else if (off == 3)
                begin
                    major_ver = b;
                end
                else if (off >= 6)
                begin
                    tag_size = {tag_size[20:0], b[6:0]};
                    if (off == 9)
                    begin
                        produced           = 1'b1;
                        rec.kind           = KIND_TAG;
                        rec.tag_version    = major_ver;
                        rec.tag_total_size = 29'(tag_size) + 29'd10;
                        consumed           = '0;
                        idx                = '0;
                        if (tag_size >= 28'd10)
                            ph = WALK_FRAME_HDR;
                        else
                            finish_walk();
                    end
                end
            end
            WALK_FRAME_HDR:
            begin
                room = 32'(tag_size) - 32'(consumed);
                if (idx == 0 && (room < 32'd10 || b == 8'h00))
                begin
                    finish_walk();
                end
                else
                begin
                    if (idx < 4)
                        hdr_ident = {hdr_ident[23:0], b};
                    else if (idx < 8)
                        hdr_len = {hdr_len[23:0], b};
                    idx++;
                    if (idx == 32'd10)
                    begin
                        consumed = consumed + 29'd10;
                        room     = 32'(tag_size) - 32'(consumed);
                        if (hdr_len == 0 || hdr_len > room)
                        begin
                            finish_walk();
                        end
                        else
                        begin
                            cur_field = NO_FIELD;
                            for (k = 0; k < 11; k++)
                                if (hdr_ident == KNOWN_IDENTS[k])
                                    cur_field = 4'(k);
                            if (cur_field == COMMENT_FIELD && hdr_len <= 32'd4)
                                cur_field = NO_FIELD;
                            saw_nul = 1'b0;
                            idx     = '0;
                            ph      = WALK_FRAME_BODY;
                        end
                    end
                end
            end
            WALK_FRAME_BODY:
            begin
                // COMM opens with an encoding byte and three language bytes
                lead = (cur_field == COMMENT_FIELD) ? 32'd4 : 32'd1;
                if (cur_field != NO_FIELD && idx >= lead)
                begin
                    if (b == 8'h00)
                        saw_nul = 1'b1;
                    produced       = 1'b1;
                    rec.kind       = KIND_TEXT;
                    rec.field_code = cur_field;
                    rec.text_byte  = b;
                    rec.text_valid = ~saw_nul;
                    rec.field_last = (idx == hdr_len - 32'd1);
                end
                idx++;
                if (idx == hdr_len)
                begin
                    consumed  = consumed + 29'(hdr_len);
                    idx       = '0;
                    hdr_ident = '0;
                    hdr_len   = '0;
                    if (32'(consumed) < 32'(tag_size))
                        ph = WALK_FRAME_HDR;
                    else
                        finish_walk();
                end
            end
            WALK_SYNC:
            begin
                if (idx >= 2 && last_two[15:8] == 8'hFF && last_two[7:5] == 3'b111)
                begin
                    produced         = 1'b1;
                    rec.kind         = KIND_RATE;
                    rec.bitrate_kbps = KBPS_BY_INDEX[b[7:4]];
                    ph               = WALK_DONE;
                end
                else
                begin
                    last_two = {last_two[7:0], b};
                    if (idx < 2)
                        idx++;
                end
            end
            default:
            begin
            end
        endcase

        if (byte_pos != '1)
            byte_pos++;
    endtask

    function automatic string rec_text(parse_rec_t r);
        return $sformatf("kind=%0d field=%0d byte=%h ok=%b last=%b ver=%h size=%0d kbps=%0d",
                         r.kind, r.field_code, r.text_byte, r.text_valid, r.field_last,
                         r.tag_version, r.tag_total_size, r.bitrate_kbps);
    endfunction

    task automatic note_failure(input string what, input string detail);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("%t checker: %s %s", $realtime, what, detail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_rec_t seen;
        parse_rec_t want;
        parse_rec_t pred;
        bit         produced;
        if (!rst_n)
        begin
            restart_parse();
            pending_records.delete();
            fails = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen.kind           = id3_kind_t'(result.kind);
                seen.field_code     = result.field_code;
                seen.text_byte      = result.text_byte;
                seen.text_valid     = result.text_valid;
                seen.field_last     = result.field_last;
                seen.tag_version    = result.tag_version;
                seen.tag_total_size = result.tag_total_size;
                seen.bitrate_kbps   = result.bitrate_kbps;
                if (pending_records.size() == 0)
                begin
                    note_failure("result with nothing pending:", rec_text(seen));
                end
                else
                begin
                    want = pending_records.pop_front();
                    if (seen.kind !== want.kind ||
                        seen.field_code !== want.field_code ||
                        seen.text_byte !== want.text_byte ||
                        seen.text_valid !== want.text_valid ||
                        seen.field_last !== want.field_last ||
                        seen.tag_version !== want.tag_version ||
                        seen.tag_total_size !== want.tag_total_size ||
                        seen.bitrate_kbps !== want.bitrate_kbps)
                        note_failure("result mismatch:",
                                     {"expected ", rec_text(want), " got ", rec_text(seen)});
                end
            end
            if (stream.valid && stream.ready)
            begin
                parse_byte(stream.data_byte, stream.first_byte, produced, pred);
                if (produced)
                    pending_records.push_back(pred);
            end
        end
        backlog = pending_records.size();
    end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the ID3v2 tag stream parser. Builds a byte stream of
// tagged files with text, comment, unknown and malformed frames, untagged
// files, truncated files and noise, then feeds it with random gaps on both
// channels, one long result back-pressure stretch and one full drain. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1100;
    localparam int IDLE_PCT    = 20;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_AT    = 550;
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 900;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    localparam logic [23:0] TAG_MAGIC = "ID3";

    localparam logic [31:0] FRAME_IDS [11] = '{
        "TIT2", "TPE1", "TALB", "TYER", "TRCK", "TCON",
        "TCOM", "TSSE", "TCOP", "WXXX", "COMM"
    };

    // {first, byte}: max-size tag header, untagged file with sync right at
    // the start, mismatch on the third and on the second header byte
    localparam logic [8:0] DIRECTED [21] = '{
        9'h149, 9'h044, 9'h033, 9'h0FF, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
        9'h1FF, 9'h0FB, 9'h0E5,
        9'h149, 9'h044, 9'h034, 9'h0FF, 9'h0E0, 9'h0F0,
        9'h149, 9'h058
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int fails;
    int backlog;
    int sent;
    int quiet;
    bit hold_done;

    logic [8:0] stim [$];

    id3_in_if  stream_if ();
    id3_out_if result_if ();

    always #5 clk = ~clk;

    id3v2_tag_stream_parser i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    id3_parse_checker i_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .result  (result_if),
        .fails   (fails),
        .backlog (backlog)
    );

    function automatic bit calm_zone();
        return sent >= CALM_FROM && sent < CALM_TO;
    endfunction

    task automatic put_frame_header(ref logic [7:0] q [$], input logic [31:0] ident,
                                    input logic [31:0] len);
        q.push_back(ident[31:24]);
        q.push_back(ident[23:16]);
        q.push_back(ident[15:8]);
        q.push_back(ident[7:0]);
        q.push_back(len[31:24]);
        q.push_back(len[23:16]);
        q.push_back(len[15:8]);
        q.push_back(len[7:0]);
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
    endtask

    task automatic put_audio_tail(ref logic [7:0] q [$]);
        repeat ($urandom_range(0, 5))
            q.push_back(8'($urandom));
        q.push_back(8'hFF);
        q.push_back({3'b111, 5'($urandom)});
        q.push_back(8'($urandom));
        repeat ($urandom_range(0, 2))
            q.push_back(8'($urandom));
    endtask

    task automatic queue_file(input logic [7:0] file [$], input int keep);
        for (int i = 0; i < keep; i++)
            stim.push_back({i == 0, file[i]});
    endtask

    task automatic add_tagged_file(input bit cut);
        logic [7:0]  body [$];
        logic [7:0]  file [$];
        logic [31:0] ident;
        logic [31:0] flen;
        logic [27:0] size;
        int          len;
        int          extra;
        int          keep;
        int          k;
        repeat ($urandom_range(0, 3))
        begin
            k = $urandom_range(0, 12);
            if (k < 11)
                ident = FRAME_IDS[k];
            else if (k == 11)
                ident = {8'($urandom_range(1, 255)), 24'($urandom)};
            else
                ident = FRAME_IDS[10];
            len = $urandom_range(1, 10);
            put_frame_header(body, ident, 32'(len));
            repeat (len)
            begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    body.push_back(8'h00);
                else if (k == 1)
                    body.push_back(8'($urandom));
                else
                    body.push_back(8'($urandom_range(32, 126)));
            end
        end
        case ($urandom_range(0, 3))
            0:
            begin
            end
            1:
            begin
                repeat ($urandom_range(1, 12))
                    body.push_back(8'h00);
            end
            2:
            begin
                extra = $urandom_range(0, 6);
                k = $urandom_range(0, 2);
                if (k == 0)
                    flen = 32'd0;
                else if (k == 1)
                    flen = 32'hFFFF_FFFF;
                else
                    flen = 32'(extra + $urandom_range(1, 3));
                put_frame_header(body, FRAME_IDS[$urandom_range(0, 10)], flen);
                repeat (extra)
                    body.push_back(8'($urandom));
            end
            default:
            begin
                // fewer than ten bytes left for the next frame header
                body.push_back(8'($urandom_range(1, 255)));
                repeat ($urandom_range(0, 8))
                    body.push_back(8'($urandom));
            end
        endcase
        size = 28'(body.size());
        file.push_back(TAG_MAGIC[23:16]);
        file.push_back(TAG_MAGIC[15:8]);
        file.push_back(TAG_MAGIC[7:0]);
        repeat (3)
            file.push_back(8'($urandom));
        file.push_back({1'($urandom), size[27:21]});
        file.push_back({1'($urandom), size[20:14]});
        file.push_back({1'($urandom), size[13:7]});
        file.push_back({1'($urandom), size[6:0]});
        file = {file, body};
        put_audio_tail(file);
        keep = cut ? $urandom_range(3, file.size() - 1) : file.size();
        queue_file(file, keep);
    endtask

    task automatic add_untagged_file();
        logic [7:0] file [$];
        logic [7:0] good;
        logic [7:0] b;
        int         pos;
        pos = $urandom_range(0, 2);
        if (pos > 0)
            file.push_back(TAG_MAGIC[23:16]);
        if (pos > 1)
            file.push_back(TAG_MAGIC[15:8]);
        good = TAG_MAGIC[8 * (2 - pos) +: 8];
        b = 8'($urandom);
        if (b == good)
            b = ~b;
        file.push_back(b);
        put_audio_tail(file);
        queue_file(file, file.size());
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
            stim.push_back({(i == 0) || ($urandom_range(0, 19) == 0), 8'($urandom)});
    endtask

    initial
    begin
        int pick;
        stream_if.valid      = 1'b0;
        stream_if.data_byte  = 8'h00;
        stream_if.first_byte = 1'b0;

        foreach (DIRECTED[i])
            stim.push_back(DIRECTED[i]);
        while (stim.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                add_tagged_file(1'b0);
            else if (pick < 75)
                add_tagged_file(1'b1);
            else if (pick < 90)
                add_untagged_file();
            else
                add_noise();
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (sent = 0; sent < stim.size(); )
        begin
            if (sent == DRAIN_AT)
            begin
                stream_if.valid <= 1'b0;
                do
                    @(negedge clk);
                while (backlog != 0);
            end
            while (!calm_zone() && $urandom_range(0, 99) < IDLE_PCT)
            begin
                stream_if.valid <= 1'b0;
                @(negedge clk);
            end
            stream_if.valid      <= 1'b1;
            stream_if.data_byte  <= stim[sent][7:0];
            stream_if.first_byte <= stim[sent][8];
            do
                @(posedge clk);
            while (!stream_if.ready);
            sent++;
            @(negedge clk);
        end
        stream_if.valid <= 1'b0;

        wait (backlog == 0);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fails == 0 && backlog == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                result_if.ready <= calm_zone() || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
